// ===== rtl/tkst_pkg.sv =====
// Shared types, constants and codes of the top-K size tracker.
`timescale 1ns / 1ps
package tkst_pkg;

  localparam int unsigned TOP_DEPTH  = 16;
  localparam int unsigned LIST_COUNT = 6;
  localparam int unsigned LIST_WORDS = LIST_COUNT * TOP_DEPTH;
  localparam int unsigned SLOT_W     = $clog2(TOP_DEPTH);
  localparam int unsigned ADDR_W     = $clog2(LIST_WORDS);

  localparam logic [4:0] LIM_MAX     = 5'(TOP_DEPTH);
  localparam logic [4:0] NO_POS      = 5'd16;
  localparam logic [4:0] LIMIT_RESET = 5'd10;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_SLOT   = 2'd1;
  localparam logic [1:0] MODE_TOTALS = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] KIND_COMMIT = 2'd0;
  localparam logic [1:0] KIND_TREE   = 2'd1;
  localparam logic [1:0] KIND_BLOB   = 2'd2;
  localparam logic [1:0] KIND_TAG    = 2'd3;

  localparam logic [1:0] RANK_COUNT    = 2'd0;
  localparam logic [1:0] RANK_DISK     = 2'd1;
  localparam logic [1:0] RANK_INFLATED = 2'd2;
  localparam logic [1:0] RANK_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic [23:0] path_id;
    logic [31:0] found_count;
    logic [31:0] missing_count;
    logic [47:0] disk_bytes;
    logic [47:0] inflated_bytes;
    logic [1:0]  ranking;
    logic [3:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [23:0] entry_path;
    logic [31:0] entry_count;
    logic [47:0] entry_disk;
    logic [47:0] entry_inflated;
    logic [31:0] total_missing;
    logic [31:0] total_reached;
    logic [4:0]  pos_by_count;
    logic [4:0]  pos_by_disk;
    logic [4:0]  pos_by_inflated;
  } out_t;

  typedef struct packed {
    logic [23:0] path;
    logic [31:0] count;
    logic [47:0] disk;
    logic [47:0] inflated;
  } entry_t;

  typedef struct packed {
    logic        we;
    logic [ADDR_W-1:0] waddr;
    entry_t      wdata;
    logic        re;
    logic [ADDR_W-1:0] raddr;
  } ram_ctl_t;

endpackage

// ===== rtl/tkst_sat_add.sv =====
// Shared saturating adder used for every per-type total.
`timescale 1ns / 1ps
module tkst_sat_add import tkst_pkg::*; (
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        wide,
  output logic [63:0] y
);

  logic [64:0] sum;
  logic        sat;

  assign sum = {1'b0, a} + {1'b0, b};
  // narrow totals saturate at the 32-bit maximum
  assign sat = sum[64] | (~wide & (|sum[63:32]));
  assign y   = sat ? (wide ? {64{1'b1}} : {32'd0, {32{1'b1}}}) : sum[63:0];

endmodule

// ===== rtl/tkst_list_ram.sv =====
// Entry memory holding all six top lists, one write and one registered read port.
`timescale 1ns / 1ps
module tkst_list_ram import tkst_pkg::*; (
  input  logic     clk,
  input  ram_ctl_t ctl,
  output entry_t   rdata
);

  entry_t mem [LIST_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// ===== rtl/top_k_size_tracker.sv =====
// Top level: sequencer, totals, list fills and result register of the size tracker.
// A commit/tag record runs the totals steps; a tree/blob record then walks each rank list too.
// A slot read issues a list memory read and waits on it; totals or unused go straight to S_DONE.
// in_ready is high only in idle, no cfg offered; a word is taken only once the last left S_DONE.
// Walk one entry per cycle through the single list memory; a full output register stalls.
// Reset clears totals, fills and handshake state, sets top_limit to 10; no clearing pass.
`timescale 1ns / 1ps
module top_k_size_tracker import tkst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOT, S_INS_BEGIN, S_INS_CMP, S_INS_END, S_RD_ISSUE, S_RD_WAIT, S_DONE
  } state_t;

  state_t      state;
  in_t         item;
  out_t        res;
  out_t        res_start;
  logic [1:0]  rank_q;
  logic [4:0]  pos;
  logic [2:0]  tstep;
  logic [31:0] fm;
  logic [4:0]  top_limit;
  logic [4:0]  fill [LIST_COUNT];

  logic [31:0] type_found   [4];
  logic [31:0] type_missing [4];
  logic [63:0] type_disk    [4];
  logic [63:0] type_inflated[4];
  logic [31:0] type_reached [4];

  logic [4:0]  lim, cfg_lim, cur_fill, fill_m1, pos_m1, pos_m2;
  logic [2:0]  list_id;
  logic [47:0] new_key, rd_key;
  logic        key_lt, rd_ok, is_list_type;
  entry_t      new_entry, rd_data;
  ram_ctl_t    ram_ctl;
  logic [63:0] sa_a, sa_b, sa_y;
  logic        sa_wide;

  // Take configuration only while idle; it wins over an input word offered at the same edge.
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Limits above the list depth act as the full depth.
  assign lim     = (top_limit > LIM_MAX) ? LIM_MAX : top_limit;
  assign cfg_lim = (cfg_data > LIM_MAX) ? LIM_MAX : cfg_data;

  assign is_list_type = (item.kind == KIND_TREE) || (item.kind == KIND_BLOB);
  assign list_id  = ((item.kind == KIND_BLOB) ? 3'd3 : 3'd0) + {1'b0, rank_q};
  assign cur_fill = fill[list_id];
  assign fill_m1  = cur_fill - 5'd1;
  assign pos_m1   = pos - 5'd1;
  assign pos_m2   = pos - 5'd2;

  assign new_entry = '{path: item.path_id, count: item.found_count,
                       disk: item.disk_bytes, inflated: item.inflated_bytes};

  always_comb begin
    case (rank_q)
      RANK_COUNT: begin
        new_key = {16'd0, item.found_count};
        rd_key  = {16'd0, rd_data.count};
      end
      RANK_DISK: begin
        new_key = item.disk_bytes;
        rd_key  = rd_data.disk;
      end
      default: begin
        new_key = item.inflated_bytes;
        rd_key  = rd_data.inflated;
      end
    endcase
  end

  // Stored entry ranks below the new record: move it one slot down.
  assign key_lt = rd_key < new_key;

  assign rd_ok = is_list_type && (item.ranking != RANK_NONE)
                 && ({1'b0, item.slot_index} < cur_fill);

  // Start value of the result word; a totals read is complete at accept.
  always_comb begin
    res_start                 = '0;
    res_start.pos_by_count    = NO_POS;
    res_start.pos_by_disk     = NO_POS;
    res_start.pos_by_inflated = NO_POS;
    if (in_data.mode == MODE_TOTALS) begin
      // Report wide totals clamped to the 48-bit field.
      res_start.entry_valid    = 1'b1;
      res_start.entry_count    = type_found[in_data.kind];
      res_start.entry_disk     = (|type_disk[in_data.kind][63:48]) ?
                                 {48{1'b1}} : type_disk[in_data.kind][47:0];
      res_start.entry_inflated = (|type_inflated[in_data.kind][63:48]) ?
                                 {48{1'b1}} : type_inflated[in_data.kind][47:0];
      res_start.total_missing  = type_missing[in_data.kind];
      res_start.total_reached  = type_reached[in_data.kind];
    end
  end

  // Shared adder operands, one total or the found+missing sum per step.
  always_comb begin
    sa_a    = '0;
    sa_b    = '0;
    sa_wide = 1'b0;
    case (tstep)
      3'd0: begin
        sa_a = {32'd0, type_found[item.kind]};
        sa_b = {32'd0, item.found_count};
      end
      3'd1: begin
        sa_a = {32'd0, type_missing[item.kind]};
        sa_b = {32'd0, item.missing_count};
      end
      3'd2: begin
        sa_a    = type_disk[item.kind];
        sa_b    = {16'd0, item.disk_bytes};
        sa_wide = 1'b1;
      end
      3'd3: begin
        sa_a    = type_inflated[item.kind];
        sa_b    = {16'd0, item.inflated_bytes};
        sa_wide = 1'b1;
      end
      3'd4: begin
        sa_a = {32'd0, item.found_count};
        sa_b = {32'd0, item.missing_count};
      end
      default: begin
        sa_a = {32'd0, type_reached[item.kind]};
        sa_b = {32'd0, fm};
      end
    endcase
  end

  tkst_sat_add u_sat_add (
    .a    (sa_a),
    .b    (sa_b),
    .wide (sa_wide),
    .y    (sa_y)
  );

  // List memory control from the sequencer state.
  always_comb begin
    ram_ctl       = '0;
    ram_ctl.wdata = rd_data;
    unique case (state)
      S_INS_BEGIN: begin
        ram_ctl.re    = (cur_fill != 5'd0);
        ram_ctl.raddr = {list_id, fill_m1[SLOT_W-1:0]};
      end
      S_INS_CMP: begin
        if (key_lt) begin
          ram_ctl.we    = (pos < lim);
          ram_ctl.waddr = {list_id, pos[SLOT_W-1:0]};
          ram_ctl.re    = (pos != 5'd1);
          ram_ctl.raddr = {list_id, pos_m2[SLOT_W-1:0]};
        end
      end
      S_INS_END: begin
        ram_ctl.we    = (pos < lim);
        ram_ctl.waddr = {list_id, pos[SLOT_W-1:0]};
        ram_ctl.wdata = new_entry;
      end
      S_RD_ISSUE: begin
        ram_ctl.re    = rd_ok;
        ram_ctl.raddr = {list_id, item.slot_index};
      end
      default: begin
      end
    endcase
  end

  tkst_list_ram u_list_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      top_limit <= LIMIT_RESET;
      tstep     <= 3'd0;
      for (int l = 0; l < LIST_COUNT; l++) begin
        fill[l] <= 5'd0;
      end
      for (int t = 0; t < 4; t++) begin
        type_found[t]    <= '0;
        type_missing[t]  <= '0;
        type_disk[t]     <= '0;
        type_inflated[t] <= '0;
        type_reached[t]  <= '0;
      end
    end else begin
      // Drop the output word once taken; the final step reloads it itself.
      if (out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item   <= in_data;
            res    <= res_start;
            rank_q <= (in_data.mode == MODE_SLOT) ? in_data.ranking : RANK_COUNT;
            tstep  <= 3'd0;
            unique case (in_data.mode)
              MODE_RECORD: state <= S_TOT;
              MODE_SLOT:   state <= S_RD_ISSUE;
              MODE_TOTALS: state <= S_DONE;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_TOT: begin
          case (tstep)
            3'd0: type_found[item.kind]    <= sa_y[31:0];
            3'd1: type_missing[item.kind]  <= sa_y[31:0];
            3'd2: type_disk[item.kind]     <= sa_y;
            3'd3: type_inflated[item.kind] <= sa_y;
            3'd4: fm <= sa_y[31:0];
            default: type_reached[item.kind] <= sa_y[31:0];
          endcase
          tstep <= tstep + 3'd1;
          if (tstep == 3'd5) begin
            state <= is_list_type ? S_INS_BEGIN : S_DONE;
          end
        end
        S_INS_BEGIN: begin
          pos   <= cur_fill;
          state <= (cur_fill != 5'd0) ? S_INS_CMP : S_INS_END;
        end
        S_INS_CMP: begin
          // Equal keys stop the walk, so the record lands after them.
          if (key_lt) begin
            pos   <= pos_m1;
            state <= (pos == 5'd1) ? S_INS_END : S_INS_CMP;
          end else begin
            state <= S_INS_END;
          end
        end
        S_INS_END: begin
          if (pos < lim && cur_fill < lim) begin
            fill[list_id] <= cur_fill + 5'd1;
          end
          case (rank_q)
            RANK_COUNT: res.pos_by_count <= (pos < lim) ? pos : NO_POS;
            RANK_DISK:  res.pos_by_disk  <= (pos < lim) ? pos : NO_POS;
            default:    res.pos_by_inflated <= (pos < lim) ? pos : NO_POS;
          endcase
          if (rank_q == RANK_INFLATED) begin
            state <= S_DONE;
          end else begin
            rank_q <= rank_q + 2'd1;
            state  <= S_INS_BEGIN;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (rd_ok) begin
            res.entry_valid    <= 1'b1;
            res.entry_path     <= rd_data.path;
            res.entry_count    <= rd_data.count;
            res.entry_disk     <= rd_data.disk;
            res.entry_inflated <= rd_data.inflated;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Cut every list down to a lowered limit.
      if (cfg_valid && cfg_ready) begin
        top_limit <= cfg_data;
        for (int l = 0; l < LIST_COUNT; l++) begin
          if (fill[l] > cfg_lim) begin
            fill[l] <= cfg_lim;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in work");

  a_fill_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (fill[0] <= lim && fill[1] <= lim && fill[2] <= lim &&
                           fill[3] <= lim && fill[4] <= lim && fill[5] <= lim))
    else $error("list fill beyond limit");

  a_pos_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_END) |-> (pos <= cur_fill))
    else $error("insert position beyond fill");
`endif

endmodule
